// ===== rtl/kwm_pkg.sv =====
package kwm_pkg;

  localparam int HEAP_CAPACITY = 16;
  localparam int ADDR_W = (HEAP_CAPACITY > 1) ? $clog2(HEAP_CAPACITY) : 1;
  localparam int COUNT_W = $clog2(HEAP_CAPACITY + 1);
  localparam int IDX_W = ADDR_W + 2;
  localparam int KEY_W = 32;
  localparam int SRC_W = 4;
  localparam int ENTRY_COUNT_W = 5;

  typedef struct packed {
    logic [SRC_W-1:0] src;
    logic [KEY_W-1:0] key;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_REPLACE = 2'd1,
    CMD_DELETE  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEL_LOAD,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_LRD,
    ST_DN_RRD,
    ST_DN_CMP,
    ST_DONE
  } state_t;

  function automatic logic key_less(input entry_t a, input entry_t b);
    return $signed(a.key) < $signed(b.key);
  endfunction

endpackage

// ===== rtl/kwm_ram.sv =====
module kwm_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/k_way_merge_min_heap.sv =====
// Channel  Dir  Handshake          Content
// s        in   s_tvalid/s_tready  tuser: command; tdata: new_key, new_source
// m        out  m_tvalid/m_tready  tuser: popped_valid, error_code; tdata: result entry
//
// An insert into an empty heap goes straight to its final write, else it sifts up one
// parent at a time. A replace sifts down from the root, reading both children of each
// node; a delete loads the last entry first unless it empties the heap. Errors and the
// unused command go straight to the result. Reset clears the count and control state.
// A new request is accepted while a result waits; its last write and its result are
// held until the output register is free, so an output stall holds the engine in ST_DONE.
module k_way_merge_min_heap
  import kwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // new_key[31:0], new_source[35:32], zero fill
  input  logic [1:0]  s_tuser,   // command[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // popped_key[31:0], popped_source[35:32], top_key[67:36],
                                 // top_source[71:68], entry_count[76:72], zero fill
  output logic [2:0]  m_tuser    // popped_valid[0], error_code[2:1]
);

  state_t state, state_next;
  logic [ADDR_W-1:0]  pos, pos_next;
  entry_t             item, item_next;
  entry_t             left, left_next;
  entry_t             root;
  entry_t             pop_ent, pop_ent_next;
  logic               pop_valid, pop_valid_next;
  err_t               err, err_next;
  logic               fin_wr, fin_wr_next;
  logic               r_ok, r_ok_next;
  logic [COUNT_W-1:0] count, count_next;

  logic               out_valid;
  entry_t             out_pop;
  logic               out_pop_valid;
  entry_t             out_top;
  logic [COUNT_W-1:0] out_count;
  err_t               out_err;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  entry_t             rd_ent, cand, top_ent, top_out;

  logic [IDX_W-1:0]   idx_l, idx_r;
  logic [ADDR_W-1:0]  up_idx;
  logic               l_in, lt_l, lt_r, lt_up, slot_free, is_full;
  cmd_t               cmd;
  entry_t             in_ent;

  kwm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(HEAP_CAPACITY)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  assign rd_ent    = entry_t'(ram_rdata);
  assign cmd       = cmd_t'(s_tuser);
  assign in_ent    = '{src: s_tdata[35:32], key: s_tdata[31:0]};
  assign idx_l     = (IDX_W'(pos) << 1) + IDX_W'(1);
  assign idx_r     = (IDX_W'(pos) << 1) + IDX_W'(2);
  assign up_idx    = (pos - ADDR_W'(1)) >> 1;
  assign l_in      = idx_l < IDX_W'(count);
  assign lt_up     = key_less(item, rd_ent);
  assign lt_l      = key_less(left, item);
  assign cand      = lt_l ? left : item;
  assign lt_r      = r_ok && key_less(rd_ent, cand);
  assign slot_free = !out_valid || m_tready;
  assign is_full   = count == COUNT_W'(HEAP_CAPACITY);
  assign s_tready  = state == ST_IDLE;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          case (cmd)
            CMD_INSERT:  state_next = (is_full || count == '0) ? ST_DONE : ST_UP_RD;
            CMD_REPLACE: state_next = (count == '0) ? ST_DONE : ST_DN_LRD;
            CMD_DELETE:  state_next = (count <= COUNT_W'(1)) ? ST_DONE : ST_DEL_LOAD;
            default:     state_next = ST_DONE;
          endcase
        end
      end
      ST_DEL_LOAD: state_next = ST_DN_LRD;
      ST_UP_RD:    state_next = ST_UP_CMP;
      ST_UP_CMP:   state_next = (lt_up && up_idx != '0) ? ST_UP_RD : ST_DONE;
      ST_DN_LRD:   state_next = l_in ? ST_DN_RRD : ST_DONE;
      ST_DN_RRD:   state_next = ST_DN_CMP;
      ST_DN_CMP:   state_next = (lt_l || lt_r) ? ST_DN_LRD : ST_DONE;
      ST_DONE:     state_next = slot_free ? ST_IDLE : ST_DONE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pos_next       = pos;
    item_next      = item;
    left_next      = left;
    pop_ent_next   = pop_ent;
    pop_valid_next = pop_valid;
    err_next       = err;
    fin_wr_next    = fin_wr;
    r_ok_next      = r_ok;
    count_next     = count;
    ram_we         = 1'b0;
    ram_waddr      = pos;
    ram_wdata      = item;
    ram_raddr      = pos;
    case (state)
      ST_IDLE: begin
        ram_raddr = ADDR_W'(count - COUNT_W'(1));
        if (s_tvalid) begin
          pop_ent_next   = '0;
          pop_valid_next = 1'b0;
          err_next       = ERR_OK;
          fin_wr_next    = 1'b0;
          pos_next       = '0;
          case (cmd)
            CMD_INSERT: begin
              if (is_full) begin
                err_next = ERR_FULL;
              end else begin
                item_next   = in_ent;
                pos_next    = ADDR_W'(count);
                count_next  = count + COUNT_W'(1);
                fin_wr_next = 1'b1;
              end
            end
            CMD_REPLACE: begin
              if (count == '0) begin
                err_next = ERR_EMPTY;
              end else begin
                pop_ent_next   = root;
                pop_valid_next = 1'b1;
                item_next      = '{src: root.src, key: in_ent.key};
                fin_wr_next    = 1'b1;
              end
            end
            CMD_DELETE: begin
              if (count == '0) begin
                err_next = ERR_EMPTY;
              end else begin
                pop_ent_next   = root;
                pop_valid_next = 1'b1;
                count_next     = count - COUNT_W'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DEL_LOAD: begin
        item_next   = rd_ent;
        fin_wr_next = 1'b1;
      end
      ST_UP_RD: begin
        ram_raddr = up_idx;
      end
      ST_UP_CMP: begin
        if (lt_up) begin
          ram_we    = 1'b1;
          ram_wdata = rd_ent;
          pos_next  = up_idx;
        end
      end
      ST_DN_LRD: begin
        ram_raddr = idx_l[ADDR_W-1:0];
      end
      ST_DN_RRD: begin
        left_next = rd_ent;
        r_ok_next = idx_r < IDX_W'(count);
        ram_raddr = idx_r[ADDR_W-1:0];
      end
      ST_DN_CMP: begin
        if (lt_r) begin
          ram_we    = 1'b1;
          ram_wdata = rd_ent;
          pos_next  = idx_r[ADDR_W-1:0];
        end else if (lt_l) begin
          ram_we    = 1'b1;
          ram_wdata = left;
          pos_next  = idx_l[ADDR_W-1:0];
        end
      end
      ST_DONE: begin
        ram_we = slot_free && fin_wr;
      end
      default: begin
      end
    endcase
  end

  assign top_ent = (ram_we && ram_waddr == '0) ? entry_t'(ram_wdata) : root;
  assign top_out = (count == '0) ? '0 : top_ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == ST_DONE && slot_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos       <= pos_next;
    item      <= item_next;
    left      <= left_next;
    pop_ent   <= pop_ent_next;
    pop_valid <= pop_valid_next;
    err       <= err_next;
    fin_wr    <= fin_wr_next;
    r_ok      <= r_ok_next;
    if (ram_we && ram_waddr == '0) begin
      root <= entry_t'(ram_wdata);
    end
    if (state == ST_DONE && slot_free) begin
      out_pop       <= pop_ent;
      out_pop_valid <= pop_valid;
      out_top       <= top_out;
      out_count     <= count;
      out_err       <= err;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, ENTRY_COUNT_W'(out_count), out_top.src, out_top.key,
                     out_pop.src, out_pop.key};
  assign m_tuser  = {out_err, out_pop_valid};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(HEAP_CAPACITY))
    else $error("entry count above capacity");

  a_write_in_heap: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (COUNT_W'(ram_waddr) < count))
    else $error("memory write outside held entries");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_err == ERR_FULL) |-> out_count == COUNT_W'(HEAP_CAPACITY))
    else $error("full error with free entries");

  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_pop_valid) |-> out_err == ERR_OK)
    else $error("popped entry reported with an error");

endmodule
